[hw/rtl/a4c_pkg.sv]
// a4c_pkg: shared types, limits and lookup tables of the 4-bit adpcm codec
// no dependencies; compiled first

package a4c_pkg;

	localparam logic signed [11:0] PRED_MAX  = 12'sd2047;
	localparam logic signed [11:0] PRED_MIN  = -12'sd2048;
	localparam logic [5:0]         INDEX_MAX = 6'd48;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic signed [11:0] pred;
		logic [5:0]         index;
	} a4c_state_t;

	typedef struct packed {
		logic signed [11:0] sample;
		logic [3:0]         code;
		logic               restart;
	} a4c_item_t;

	// step size table, indexes at or above the top entry read the last step
	function automatic logic [10:0] step_size(input logic [5:0] idx);
		logic [10:0] s;
		case (idx)
			6'd0:  s = 11'd16;
			6'd1:  s = 11'd17;
			6'd2:  s = 11'd19;
			6'd3:  s = 11'd21;
			6'd4:  s = 11'd23;
			6'd5:  s = 11'd25;
			6'd6:  s = 11'd28;
			6'd7:  s = 11'd31;
			6'd8:  s = 11'd34;
			6'd9:  s = 11'd37;
			6'd10: s = 11'd41;
			6'd11: s = 11'd45;
			6'd12: s = 11'd50;
			6'd13: s = 11'd55;
			6'd14: s = 11'd60;
			6'd15: s = 11'd66;
			6'd16: s = 11'd73;
			6'd17: s = 11'd80;
			6'd18: s = 11'd88;
			6'd19: s = 11'd97;
			6'd20: s = 11'd107;
			6'd21: s = 11'd118;
			6'd22: s = 11'd130;
			6'd23: s = 11'd143;
			6'd24: s = 11'd157;
			6'd25: s = 11'd173;
			6'd26: s = 11'd190;
			6'd27: s = 11'd209;
			6'd28: s = 11'd230;
			6'd29: s = 11'd253;
			6'd30: s = 11'd279;
			6'd31: s = 11'd307;
			6'd32: s = 11'd337;
			6'd33: s = 11'd371;
			6'd34: s = 11'd408;
			6'd35: s = 11'd449;
			6'd36: s = 11'd494;
			6'd37: s = 11'd544;
			6'd38: s = 11'd598;
			6'd39: s = 11'd658;
			6'd40: s = 11'd724;
			6'd41: s = 11'd796;
			6'd42: s = 11'd876;
			6'd43: s = 11'd963;
			6'd44: s = 11'd1060;
			6'd45: s = 11'd1166;
			6'd46: s = 11'd1282;
			6'd47: s = 11'd1411;
			default: s = 11'd1552;
		endcase
		return s;
	endfunction

	function automatic logic signed [4:0] idx_delta(input logic [2:0] mag);
		logic signed [4:0] d;
		case (mag)
			3'd4:    d = 5'sd2;
			3'd5:    d = 5'sd4;
			3'd6:    d = 5'sd6;
			3'd7:    d = 5'sd8;
			default: d = -5'sd1;
		endcase
		return d;
	endfunction

endpackage

[hw/rtl/a4c_if.sv]
// a4c_in_if / a4c_out_if: valid/ready channels of the adpcm codec
// no dependencies

interface a4c_in_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] sample_in;
	logic [3:0]         code_in;
	logic               restart;

	modport source (output valid, output sample_in, output code_in, output restart,
		input ready);
	modport sink (input valid, input sample_in, input code_in, input restart,
		output ready);
endinterface

interface a4c_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         code_out;
	logic signed [11:0] sample_out;

	modport source (output valid, output code_out, output sample_out, input ready);
	modport sink (input valid, input code_out, input sample_out, output ready);
endinterface

[hw/rtl/adpcm_4bit_codec_top.sv]
// adpcm_4bit_codec_top: 4-bit adpcm encoder/decoder on 12-bit samples
// uses a4c_pkg, a4c_in_if, a4c_out_if and a4c_datapath
//
// path: each item passes the input register, then the codec step into the result
// register; throughput one item per cycle while result_ch.ready is high, as the
// predictor/step-index feedback through a4c_datapath is combinational; a stalled
// result holds the step and the input register
// reset: arst_n clears mode (encode), predictor, step index and both valid flags

module adpcm_4bit_codec_top (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mode_we,
	input  logic      mode_wdata,
	a4c_in_if.sink    sample_ch,
	a4c_out_if.source result_ch
);
	import a4c_pkg::*;

	logic       mode_q;
	logic       valid_s1;
	a4c_item_t  item_s1;
	a4c_state_t state_q;
	a4c_state_t state_nxt;
	logic [3:0] code_nxt;
	logic       out_valid_q;
	logic [3:0] out_code_q;
	logic [11:0] out_sample_q;
	logic       advance;

	// step fires when the result register is free or being emptied
	assign advance         = valid_s1 && (!out_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;

	a4c_datapath u_datapath (
		.st   (state_q),
		.mode (mode_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.code (code_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ENCODE;
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mode_we) begin
				mode_q <= mode_wdata;
			end
			if (sample_ch.ready) begin
				valid_s1 <= sample_ch.valid;
			end
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.ready && sample_ch.valid) begin
			item_s1.sample  <= sample_ch.sample_in;
			item_s1.code    <= sample_ch.code_in;
			item_s1.restart <= sample_ch.restart;
		end
		if (advance) begin
			out_code_q   <= code_nxt;
			out_sample_q <= state_nxt.pred;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.code_out   = out_code_q;
	assign result_ch.sample_out = out_sample_q;

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.index <= INDEX_MAX)
		else $error("step index above table range");

	a_sample_is_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (result_ch.sample_out == state_q.pred))
		else $error("reconstructed sample differs from stored predictor");

	a_decode_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_q == MODE_DECODE) |=> (result_ch.code_out == $past(item_s1.code)))
		else $error("decoded transaction did not echo its code");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_ch.ready) |=> $stable(state_q))
		else $error("state moved while a result was stalled");

endmodule

[hw/rtl/a4c_datapath.sv]
// a4c_datapath: one codec step, quantize (or take the code), dequantize,
// update predictor and step index; purely combinational, uses a4c_pkg

module a4c_datapath (
	input  a4c_pkg::a4c_state_t st,
	input  logic                mode,
	input  a4c_pkg::a4c_item_t  item,
	output a4c_pkg::a4c_state_t nxt,
	output logic [3:0]          code
);
	import a4c_pkg::*;

	a4c_state_t         cur;
	logic [5:0]         idx;
	logic [10:0]        step;
	logic [11:0]        stepx;
	logic signed [12:0] diff;
	logic [11:0]        mag0;
	logic [11:0]        mag1;
	logic [11:0]        mag2;
	logic [3:0]         qcode;
	logic [11:0]        dq;
	logic signed [13:0] sum;
	logic signed [4:0]  delta;
	logic signed [7:0]  ni;

	always_comb begin
		cur   = item.restart ? '0 : st;
		idx   = (cur.index > INDEX_MAX) ? INDEX_MAX : cur.index;
		step  = step_size(idx);
		stepx = {1'b0, step};

		// sign then three successive-approximation magnitude bits
		diff     = {item.sample[11], item.sample} - {cur.pred[11], cur.pred};
		qcode[3] = diff[12];
		mag0     = diff[12] ? 12'(-diff) : diff[11:0];
		qcode[2] = (mag0 >= stepx);
		mag1     = qcode[2] ? (mag0 - stepx) : mag0;
		qcode[1] = (mag1 >= (stepx >> 1));
		mag2     = qcode[1] ? (mag1 - (stepx >> 1)) : mag1;
		qcode[0] = (mag2 >= (stepx >> 2));

		code = (mode == MODE_DECODE) ? item.code : qcode;

		dq = (stepx >> 3)
			+ (code[2] ? stepx : 12'd0)
			+ (code[1] ? (stepx >> 1) : 12'd0)
			+ (code[0] ? (stepx >> 2) : 12'd0);

		if (code[3]) begin
			sum = {{2{cur.pred[11]}}, cur.pred} - {2'b00, dq};
		end else begin
			sum = {{2{cur.pred[11]}}, cur.pred} + {2'b00, dq};
		end

		if (sum > 14'sd2047) begin
			nxt.pred = PRED_MAX;
		end else if (sum < -14'sd2048) begin
			nxt.pred = PRED_MIN;
		end else begin
			nxt.pred = sum[11:0];
		end

		delta = idx_delta(code[2:0]);
		ni    = $signed({2'b00, idx}) + {{3{delta[4]}}, delta};
		if (ni < 8'sd0) begin
			nxt.index = 6'd0;
		end else if (ni > 8'sd48) begin
			nxt.index = INDEX_MAX;
		end else begin
			nxt.index = ni[5:0];
		end
	end

endmodule
